### hdl/block_mosaic_pixelator_assert.svh
// ----------------------------------------------------------------------------
// Mosaic pixelator assertion macros
// Shared wrappers for the concurrent checks on clk and rst.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MOSAIC_PIXELATOR_ASSERT_SVH
`define BLOCK_MOSAIC_PIXELATOR_ASSERT_SVH

// check a property outside reset
`define MMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mosaic pixelator check failed");

// check a property at every edge, reset included
`define MMP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mosaic pixelator reset check failed");

`endif

### hdl/mmp_pkg.sv
// ----------------------------------------------------------------------------
// Mosaic pixelator package
// Frame geometry, command format and back-end states.
// ----------------------------------------------------------------------------
package mmp_pkg;

  localparam int FRAME_WIDTH  = 80;
  localparam int FRAME_HEIGHT = 120;
  localparam int MAX_BLOCK    = 40;
  localparam int NUM_COLS     = (FRAME_WIDTH + 1) / 2;
  localparam int COL_AW       = $clog2(NUM_COLS);
  localparam int XW           = 7;
  localparam int YW           = 7;
  localparam int SW           = 6;
  localparam int SUM_W        = 19;
  localparam int CNT_W        = 12;
  localparam int FIFO_DEPTH   = 4;

  // one unit of work handed from front to back
  typedef struct packed {
    logic              clr;
    logic              pass;
    logic              emit;
    logic              row_end;
    logic              frame_end;
    logic [SW-1:0]     n;
    logic [COL_AW-1:0] idx;
    logic [XW-1:0]     x;
    logic [YW-1:0]     y;
    logic [SW-1:0]     h;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } cmd_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_ACC_RD,
    B_ACC_WR,
    B_EM_RD,
    B_EM_LD,
    B_EM_DIV,
    B_EM_OUT,
    B_PASS_OUT
  } back_state_t;

endpackage

### hdl/mmp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/mmp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module mmp_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  mmp_pkg::cmd_t wdata,
  output logic          full,
  input  logic          rd,
  output mmp_pkg::cmd_t rdata,
  output logic          empty
);
  import mmp_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  cmd_t          entries [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  // store on write
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/mmp_front.sv
// ----------------------------------------------------------------------------
// Mosaic front end
// Tracks raster position and strip row, classifies each pixel into a command.
// ----------------------------------------------------------------------------
module mmp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    pixel_red,
  input  logic [7:0]    pixel_green,
  input  logic [7:0]    pixel_blue,
  input  logic          frame_start,
  input  logic          block_size_write,
  input  logic [5:0]    block_size,
  input  logic          q_full,
  output logic          q_wr,
  output mmp_pkg::cmd_t q_cmd
);
  import mmp_pkg::*;

  logic [XW-1:0]     col;
  logic [YW-1:0]     row;
  logic [SW-1:0]     row_in_strip;
  logic [SW-1:0]     edge_n;
  logic [SW-1:0]     bsize;
  logic [COL_AW-1:0] blk_idx;
  logic [SW-1:0]     in_blk;

  logic [XW-1:0]     c0;
  logic [YW-1:0]     r0;
  logic [SW-1:0]     ris0;
  logic [COL_AW-1:0] idx0;
  logic [SW-1:0]     inb0;
  logic [SW-1:0]     n0;
  logic [SW-1:0]     bs_clamp;
  logic              row_end;
  logic              frame_end;
  logic              emit;
  logic              accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_wr   = accept;

  // classify the incoming pixel
  always_comb begin
    c0   = frame_start ? '0 : col;
    r0   = frame_start ? '0 : row;
    ris0 = frame_start ? '0 : row_in_strip;
    idx0 = frame_start ? '0 : blk_idx;
    inb0 = frame_start ? '0 : in_blk;
    if (bsize == '0) begin
      bs_clamp = SW'(1);
    end else if (bsize > SW'(MAX_BLOCK)) begin
      bs_clamp = SW'(MAX_BLOCK);
    end else begin
      bs_clamp = bsize;
    end
    n0        = (c0 == '0 && r0 == '0) ? bs_clamp : edge_n;
    row_end   = (c0 == XW'(FRAME_WIDTH - 1));
    frame_end = row_end && (r0 == YW'(FRAME_HEIGHT - 1));
    emit      = row_end && ((ris0 + 1'b1) >= n0 || frame_end);

    q_cmd.clr       = frame_start;
    q_cmd.pass      = (n0 == SW'(1));
    q_cmd.emit      = emit;
    q_cmd.row_end   = row_end;
    q_cmd.frame_end = frame_end;
    q_cmd.n         = n0;
    q_cmd.idx       = idx0;
    q_cmd.x         = c0;
    q_cmd.y         = (n0 == SW'(1)) ? r0 : r0 - YW'(ris0);
    q_cmd.h         = ris0 + 1'b1;
    q_cmd.red       = pixel_red;
    q_cmd.green     = pixel_green;
    q_cmd.blue      = pixel_blue;
  end

  // advance position on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      col          <= '0;
      row          <= '0;
      row_in_strip <= '0;
      blk_idx      <= '0;
      in_blk       <= '0;
      edge_n       <= SW'(1);
      bsize        <= SW'(1);
    end else begin
      if (block_size_write) begin
        bsize <= block_size;
      end
      if (accept) begin
        edge_n <= n0;
        if (row_end) begin
          col     <= '0;
          blk_idx <= '0;
          in_blk  <= '0;
          row     <= frame_end ? '0 : r0 + 1'b1;
        end else begin
          col <= c0 + 1'b1;
          row <= r0;
          if (inb0 == n0 - 1'b1) begin
            blk_idx <= idx0 + 1'b1;
            in_blk  <= '0;
          end else begin
            blk_idx <= idx0;
            in_blk  <= inb0 + 1'b1;
          end
        end
        if (frame_end || (row_end && emit)) begin
          row_in_strip <= '0;
        end else if (row_end && n0 != SW'(1)) begin
          row_in_strip <= ris0 + 1'b1;
        end else begin
          row_in_strip <= ris0;
        end
      end
    end
  end

endmodule

### hdl/mmp_back.sv
// ----------------------------------------------------------------------------
// Mosaic back end
// Accumulates column sums, divides them out per block or passes single pixels, and drives results.
// ----------------------------------------------------------------------------
module mmp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  mmp_pkg::cmd_t q_cmd,
  output logic          q_rd,
  output logic          empty,
  input  logic          pop,
  output logic [6:0]    block_x,
  output logic [6:0]    block_y,
  output logic [5:0]    block_width,
  output logic [5:0]    block_height,
  output logic [7:0]    avg_red,
  output logic [7:0]    avg_green,
  output logic [7:0]    avg_blue,
  output logic          last_of_strip,
  output logic          last_of_frame
);
  import mmp_pkg::*;

  localparam int RW = 3 * SUM_W;

  back_state_t       state;
  back_state_t       state_next;
  cmd_t              cur;
  logic              out_valid;
  logic [COL_AW-1:0] clr_idx;
  logic [COL_AW-1:0] k;
  logic [XW:0]       x;
  logic [SW-1:0]     w;
  logic [CNT_W-1:0]  cnt;
  logic [2:0]        bitc;
  logic [SUM_W-1:0]  rem_r, rem_g, rem_b;
  logic [7:0]        q_r, q_g, q_b;

  logic              ram_we;
  logic [COL_AW-1:0] ram_waddr;
  logic [RW-1:0]     ram_wdata;
  logic              ram_re;
  logic [COL_AW-1:0] ram_raddr;
  logic [RW-1:0]     ram_rdata;

  logic [SW-1:0]     w_calc;
  logic [XW:0]       x_rem;
  logic [SUM_W-1:0]  div_d;
  logic              blk_last;
  logic              load_out;

  mmp_ram #(.WIDTH(RW), .DEPTH(NUM_COLS)) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign empty    = !out_valid;
  assign x_rem    = (XW+1)'(FRAME_WIDTH) - x;
  assign w_calc   = (x_rem > (XW+1)'(cur.n)) ? cur.n : SW'(x_rem);
  assign div_d    = SUM_W'(cnt) << bitc;
  assign blk_last = (x + (XW+1)'(cur.n)) >= (XW+1)'(FRAME_WIDTH);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: begin
        if (clr_idx == COL_AW'(NUM_COLS - 1)) begin
          if (!cur.clr) begin
            state_next = B_IDLE;
          end else begin
            state_next = cur.pass ? B_PASS_OUT : B_ACC_RD;
          end
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.clr) begin
            state_next = B_CLEAR;
          end else begin
            state_next = q_cmd.pass ? B_PASS_OUT : B_ACC_RD;
          end
        end
      end
      B_ACC_RD:   state_next = B_ACC_WR;
      B_ACC_WR:   state_next = cur.emit ? B_EM_RD : B_IDLE;
      B_EM_RD:    state_next = B_EM_LD;
      B_EM_LD:    state_next = B_EM_DIV;
      B_EM_DIV:   state_next = (bitc == '0) ? B_EM_OUT : B_EM_DIV;
      B_EM_OUT: begin
        if (!out_valid) begin
          state_next = blk_last ? B_IDLE : B_EM_RD;
        end
      end
      B_PASS_OUT: begin
        if (!out_valid) begin
          state_next = B_IDLE;
        end
      end
      default:    state_next = B_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    q_rd      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur.idx;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cur.idx;
    load_out  = 1'b0;
    case (state)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
      end
      B_IDLE:   q_rd = !q_empty;
      B_ACC_RD: ram_re = 1'b1;
      B_ACC_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {ram_rdata[RW-1 -: SUM_W] + SUM_W'(cur.red),
                     ram_rdata[2*SUM_W-1 -: SUM_W] + SUM_W'(cur.green),
                     ram_rdata[SUM_W-1:0] + SUM_W'(cur.blue)};
      end
      B_EM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = k;
      end
      B_EM_LD: begin
        ram_we    = 1'b1;
        ram_waddr = k;
      end
      B_EM_OUT:   load_out = !out_valid;
      B_PASS_OUT: load_out = !out_valid;
      default:    q_rd = 1'b0;
    endcase
  end

  // hold control state and the current command
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      out_valid <= 1'b0;
      clr_idx   <= '0;
      cur.clr   <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (state == B_CLEAR) begin
        clr_idx <= (clr_idx == COL_AW'(NUM_COLS - 1)) ? '0 : clr_idx + 1'b1;
      end
      if (q_rd) begin
        cur <= q_cmd;
      end
    end
  end

  // block walk and divider datapath
  always_ff @(posedge clk) begin
    case (state)
      B_ACC_WR: begin
        k <= '0;
        x <= '0;
      end
      B_EM_RD: begin
        w   <= w_calc;
        cnt <= CNT_W'(w_calc) * CNT_W'(cur.h);
      end
      B_EM_LD: begin
        rem_r <= ram_rdata[RW-1 -: SUM_W];
        rem_g <= ram_rdata[2*SUM_W-1 -: SUM_W];
        rem_b <= ram_rdata[SUM_W-1:0];
        q_r   <= '0;
        q_g   <= '0;
        q_b   <= '0;
        bitc  <= 3'd7;
      end
      B_EM_DIV: begin
        // one restoring step per channel
        if (rem_r >= div_d) begin
          rem_r       <= rem_r - div_d;
          q_r[bitc]   <= 1'b1;
        end
        if (rem_g >= div_d) begin
          rem_g       <= rem_g - div_d;
          q_g[bitc]   <= 1'b1;
        end
        if (rem_b >= div_d) begin
          rem_b       <= rem_b - div_d;
          q_b[bitc]   <= 1'b1;
        end
        bitc <= bitc - 1'b1;
      end
      B_EM_OUT: begin
        if (!out_valid) begin
          k <= k + 1'b1;
          x <= x + (XW+1)'(cur.n);
        end
      end
      default: begin
        k <= k;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == B_PASS_OUT) begin
        block_x       <= cur.x;
        block_y       <= cur.y;
        block_width   <= SW'(1);
        block_height  <= SW'(1);
        avg_red       <= cur.red;
        avg_green     <= cur.green;
        avg_blue      <= cur.blue;
        last_of_strip <= cur.row_end;
        last_of_frame <= cur.frame_end;
      end else begin
        block_x       <= XW'(x);
        block_y       <= cur.y;
        block_width   <= w;
        block_height  <= cur.h;
        avg_red       <= q_r;
        avg_green     <= q_g;
        avg_blue      <= q_b;
        last_of_strip <= blk_last;
        last_of_frame <= blk_last && cur.frame_end;
      end
    end
  end

endmodule

### hdl/block_mosaic_pixelator.sv
// ----------------------------------------------------------------------------
// Mosaic pixelator top level
// Averages an 80 x 120 RGB888 raster over N x N blocks.
// ----------------------------------------------------------------------------
// Pixels go in row-major order; each takes one slot in a four-entry command
// queue and is then accumulated by the back end (queue read, then read and
// write of the column-sum memory). At the end of a strip the back end walks
// the block columns; for each block it reads the memory and multiplies for
// the pixel count, loads the sums, runs an eight-step divider and loads the
// result once the result register is free. With N of 1 each pixel is passed
// straight through as a result. After reset, and on a frame_start, the back
// end clears the sum memory first.
module block_mosaic_pixelator (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] pixel_red,
  input  logic [7:0] pixel_green,
  input  logic [7:0] pixel_blue,
  input  logic       frame_start,
  input  logic       block_size_write,
  input  logic [5:0] block_size,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] block_x,
  output logic [6:0] block_y,
  output logic [5:0] block_width,
  output logic [5:0] block_height,
  output logic [7:0] avg_red,
  output logic [7:0] avg_green,
  output logic [7:0] avg_blue,
  output logic       last_of_strip,
  output logic       last_of_frame
);
  import mmp_pkg::*;

  cmd_t f_cmd;
  cmd_t b_cmd;
  logic f_wr;
  logic q_full;
  logic q_empty;
  logic q_rd;

  mmp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .pixel_red        (pixel_red),
    .pixel_green      (pixel_green),
    .pixel_blue       (pixel_blue),
    .frame_start      (frame_start),
    .block_size_write (block_size_write),
    .block_size       (block_size),
    .q_full           (q_full),
    .q_wr             (f_wr),
    .q_cmd            (f_cmd)
  );

  mmp_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (f_wr),
    .wdata (f_cmd),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (b_cmd),
    .empty (q_empty)
  );

  mmp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_cmd         (b_cmd),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .block_x       (block_x),
    .block_y       (block_y),
    .block_width   (block_width),
    .block_height  (block_height),
    .avg_red       (avg_red),
    .avg_green     (avg_green),
    .avg_blue      (avg_blue),
    .last_of_strip (last_of_strip),
    .last_of_frame (last_of_frame)
  );

endmodule

### hdl/mmp_checker.sv
// ----------------------------------------------------------------------------
// Mosaic pixelator checker
// Port-level checks on the result side, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_mosaic_pixelator_assert.svh"

module mmp_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [6:0] block_x,
  input logic [5:0] block_width,
  input logic [5:0] block_height,
  input logic       last_of_strip,
  input logic       last_of_frame
);
  import mmp_pkg::*;

  // nothing waits straight after reset
  `MMP_ASSERT_ALWAYS(a_empty_after_rst, rst |=> empty)
  // a held result keeps its place
  `MMP_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(block_x)))
  // the frame ends only on a strip end
  `MMP_ASSERT(a_frame_strip, !empty |-> (!last_of_frame || last_of_strip))
  // clipped sizes stay in range
  `MMP_ASSERT(a_size, !empty |-> (block_width != '0 && block_height != '0 &&
    block_width <= 6'(MAX_BLOCK) && block_height <= 6'(MAX_BLOCK)))

endmodule

bind block_mosaic_pixelator mmp_checker u_mmp_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mosaic pixelator testbench
// Streams RGB888 pixels through the pixelator under several block sizes,
// predicts every block average in a scoreboard and checks each result
// transfer field by field, with random idling on both queue interfaces.
// ----------------------------------------------------------------------------
module tb_top;
  import mmp_pkg::*;

  localparam int IDLE_WAIT      = 600;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [6:0] x;
    logic [6:0] y;
    logic [5:0] w;
    logic [5:0] h;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       strip_last;
    logic       frame_last;
  } mosaic_block_t;

  // block-average predictor and store of pending blocks
  class mosaic_scoreboard;
    mosaic_block_t pending_blocks[$];
    int unsigned   red_acc[NUM_COLS];
    int unsigned   green_acc[NUM_COLS];
    int unsigned   blue_acc[NUM_COLS];
    int unsigned   col_pos, row_pos, strip_row, edge_len, size_reg;
    int            mismatches, blocks_checked, pixels_taken;

    function new();
      clear_sums();
      col_pos = 0; row_pos = 0; strip_row = 0;
      edge_len = 1; size_reg = 1;
      mismatches = 0; blocks_checked = 0; pixels_taken = 0;
    endfunction

    function void clear_sums();
      for (int i = 0; i < NUM_COLS; i++) begin
        red_acc[i] = 0; green_acc[i] = 0; blue_acc[i] = 0;
      end
    endfunction

    function void set_block_size(logic [5:0] v);
      size_reg = v;
    endfunction

    // note an accepted pixel and queue the blocks it completes
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
      mosaic_block_t blk;
      int unsigned   idx, nb, h, top, x, w, cnt;
      bit            row_done, frame_done;
      pixels_taken++;
      if (fs) begin
        clear_sums();
        col_pos = 0; row_pos = 0; strip_row = 0;
      end
      if (col_pos == 0 && row_pos == 0) begin
        edge_len = size_reg;
        if (edge_len < 1) edge_len = 1;
        if (edge_len > MAX_BLOCK) edge_len = MAX_BLOCK;
      end
      row_done   = (col_pos >= FRAME_WIDTH - 1);
      frame_done = row_done && (row_pos >= FRAME_HEIGHT - 1);
      if (edge_len <= 1) begin
        blk = '{7'(col_pos), 7'(row_pos), 6'd1, 6'd1, r, g, b, row_done, frame_done};
        pending_blocks.push_back(blk);
      end else begin
        idx = col_pos / edge_len;
        if (idx < NUM_COLS) begin
          red_acc[idx] += r; green_acc[idx] += g; blue_acc[idx] += b;
        end
        if (row_done) begin
          if (strip_row + 1 >= edge_len || frame_done) begin
            h   = strip_row + 1;
            top = row_pos - strip_row;
            nb  = (FRAME_WIDTH + edge_len - 1) / edge_len;
            if (nb > NUM_COLS) nb = NUM_COLS;
            for (int k = 0; k < nb; k++) begin
              x = k * edge_len;
              w = FRAME_WIDTH - x;
              if (w > edge_len) w = edge_len;
              cnt = w * h;
              blk = '{7'(x), 7'(top), 6'(w), 6'(h), 8'(red_acc[k] / cnt),
                      8'(green_acc[k] / cnt), 8'(blue_acc[k] / cnt),
                      k + 1 == nb, (k + 1 == nb) && frame_done};
              pending_blocks.push_back(blk);
            end
            clear_sums();
            strip_row = 0;
          end else begin
            strip_row++;
          end
        end
      end
      // advance the raster position
      if (row_done) begin
        col_pos = 0;
        if (frame_done) begin
          row_pos = 0; strip_row = 0;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
    endfunction

    function void check_block(mosaic_block_t got);
      mosaic_block_t want;
      blocks_checked++;
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected block %p", $realtime, got);
        return;
      end
      want = pending_blocks.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
          got.h !== want.h || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.strip_last !== want.strip_last ||
          got.frame_last !== want.frame_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: block mismatch\n  expected %p\n  actual   %p",
                   $realtime, want, got);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] pixel_red = '0, pixel_green = '0, pixel_blue = '0;
  logic       frame_start = 1'b0;
  logic       block_size_write = 1'b0;
  logic [5:0] block_size = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [6:0] block_x, block_y;
  logic [5:0] block_width, block_height;
  logic [7:0] avg_red, avg_green, avg_blue;
  logic       last_of_strip, last_of_frame;

  mosaic_scoreboard sb = new();
  bit idling_on  = 1'b1;
  int quiet_cycles = 0;
  bit transfer_seen;

  block_mosaic_pixelator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // drain side: pop with random stall bursts
  int pop_stall = 0;
  always @(negedge clk) begin
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      pop_stall = $urandom_range(1, 19) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // check every result transfer and run the watchdog
  always @(posedge clk) begin
    transfer_seen = push && !full;
    if (!rst && pop && !empty) begin
      sb.check_block('{block_x, block_y, block_width, block_height, avg_red,
                       avg_green, avg_blue, last_of_strip, last_of_frame});
      transfer_seen = 1'b1;
    end
    quiet_cycles = transfer_seen ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d blocks pending", sb.pending_blocks.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [7:0] pick_channel(bit saturate);
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (saturate || sel == 0) return 8'hFF;
    if (sel == 1) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // push one pixel, holding it until the transfer happens
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    push        <= 1'b1;
    pixel_red   <= r;
    pixel_green <= g;
    pixel_blue  <= b;
    frame_start <= fs;
    do @(posedge clk); while (full);
    sb.note_pixel(r, g, b, fs);
  endtask

  // push a run of random pixels, the first one optionally opening a frame
  task automatic send_run(int count, bit open_frame, bit saturate);
    for (int i = 0; i < count; i++)
      send_pixel(pick_channel(saturate), pick_channel(saturate),
                 pick_channel(saturate), open_frame && i == 0);
  endtask

  // drain, let the back end settle, then write the register
  task automatic write_block_size(logic [5:0] v);
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending_blocks.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
    block_size_write <= 1'b1;
    block_size       <= v;
    @(negedge clk);
    block_size_write <= 1'b0;
    sb.set_block_size(v);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // pass-through at reset size: extremes, bit patterns, frame restart
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
    send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
    send_run(20, 1'b0, 1'b0);

    // oversized register clamps to the largest block; partial strip only
    write_block_size(6'd63);
    send_run(4, 1'b1, 1'b0);

    // zero counts as no mosaic; the restart drops the partial strip
    write_block_size(6'd0);
    send_run(5, 1'b1, 1'b0);

    // one whole strip of 2 x 2 blocks, saturated first row, no idling at the end
    write_block_size(6'd2);
    send_run(FRAME_WIDTH, 1'b1, 1'b1);
    idling_on = 1'b0;
    send_run(FRAME_WIDTH, 1'b0, 1'b0);

    // drain and settle
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending_blocks.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);

    $display("covered %0d pixels and %0d block results: pass-through, clamped sizes,",
             sb.pixels_taken, sb.blocks_checked);
    $display("restarts and a full strip of small blocks; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_blocks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
